FILE: rtl/core/gbs_pkg.sv
// gbs_pkg: beat types and the threshold reset constant shared by the greedy box suppression block
// no dependencies

package gbs_pkg;

    localparam logic [15:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic              first_of_frame;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic [15:0]       box_width;
        logic [15:0]       box_height;
    } in_beat_t;

    typedef struct packed {
        logic        keep;
        logic [15:0] box_index;
        logic [5:0]  kept_slot;
        logic        overflow;
    } out_beat_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [15:0]        width;
        logic [15:0]        height;
    } box_t;

endpackage

FILE: rtl/core/greedy_box_suppression.sv
// greedy_box_suppression: greedy overlap suppression of score-sorted boxes, depends on gbs_pkg
// each input beat scans the kept list: one memory read per cycle feeds a five-stage overlap
// pipeline, a suppressing match ends the scan early, and an empty kept list needs no read;
// the result waits in its final state while the output is stalled
// one box in work at a time, the next accepted in the cycle after the result registers
// reset (async, active low) empties the kept list, zeroes the frame counter, loads 29491

module greedy_box_suppression #(
    parameter int MAX_KEPT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  gbs_pkg::in_beat_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gbs_pkg::out_beat_t  out_data
);

    localparam int AW     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW     = $clog2(MAX_KEPT + 1);
    localparam int SLOT_W = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_KEPT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // control
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   counter_reg, counter_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          hit_reg, hit_next;
    logic          out_valid_reg, out_valid_next;
    logic [5:0]    v_reg, v_next;
    logic [15:0]   thr_reg;

    // payload
    gbs_pkg::box_t      cur_reg;
    logic [31:0]        ap_reg;
    logic [15:0]        idx_reg;
    gbs_pkg::out_beat_t out_data_reg;

    // kept-box memory
    logic [63:0]   mem [MAX_KEPT];
    gbs_pkg::box_t rdata_reg;
    logic          rd_en;
    logic          mem_we;

    // overlap pipeline
    logic signed [17:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [15:0]        qw1_reg, qh1_reg;
    logic [15:0]        dx_reg, dy_reg, qw2_reg, qh2_reg;
    logic [31:0]        inter3_reg, aq_reg;
    logic [32:0]        uni_reg;
    logic [31:0]        inter4_reg;
    logic [48:0]        prod_reg;
    logic [47:0]        big_reg;
    logic               nz_reg;

    logic signed [17:0] cl, ct, cr, cb, ql, qt, qr, qb;
    logic signed [17:0] dx_diff, dy_diff;
    logic [48:0]        prod_c;
    logic               hit;
    logic               accept;
    logic               fin_fire;
    logic               keep_box;
    logic               room;
    logic [SLOT_W-1:0]  slot_wide;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign hit      = v_reg[5] && nz_reg && ({1'b0, big_reg} > prod_reg);
    assign rd_en    = (state_reg == S_RUN) && !hit && (issue_reg < count_reg);
    assign fin_fire = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign keep_box = !hit_reg;
    assign room     = (count_reg < MAX_CNT);
    assign mem_we   = fin_fire && keep_box && room;
    assign slot_wide = SLOT_W'(count_reg);

    // edges of current and stored box
    assign cl = {{2{cur_reg.left[15]}}, cur_reg.left};
    assign ct = {{2{cur_reg.top[15]}}, cur_reg.top};
    assign cr = cl + $signed({2'b00, cur_reg.width});
    assign cb = ct + $signed({2'b00, cur_reg.height});
    assign ql = {{2{rdata_reg.left[15]}}, rdata_reg.left};
    assign qt = {{2{rdata_reg.top[15]}}, rdata_reg.top};
    assign qr = ql + $signed({2'b00, rdata_reg.width});
    assign qb = qt + $signed({2'b00, rdata_reg.height});

    assign dx_diff = x1_reg - x0_reg;
    assign dy_diff = y1_reg - y0_reg;
    assign prod_c  = thr_reg * uni_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        counter_next   = counter_reg;
        issue_next     = issue_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        v_next         = hit ? 6'd0 : {v_reg[4:0], rd_en};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.first_of_frame)
                    begin
                        count_next   = '0;
                        counter_next = 16'd1;
                    end
                    else
                    begin
                        counter_next = counter_reg + 16'd1;
                    end
                    issue_next = '0;
                    hit_next   = 1'b0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                if (hit)
                begin
                    hit_next   = 1'b1;
                    state_next = S_FIN;
                end
                else if ((issue_reg == count_reg) && (v_reg == 6'd0))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fin_fire)
                begin
                    out_valid_next = 1'b1;
                    if (mem_we)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            counter_reg   <= '0;
            issue_reg     <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            v_reg         <= '0;
            thr_reg       <= gbs_pkg::THR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            counter_reg   <= counter_next;
            issue_reg     <= issue_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            v_reg         <= v_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // current box and result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg.left   <= in_data.box_left;
            cur_reg.top    <= in_data.box_top;
            cur_reg.width  <= in_data.box_width;
            cur_reg.height <= in_data.box_height;
            idx_reg        <= in_data.first_of_frame ? 16'd0 : counter_reg;
        end
        ap_reg <= cur_reg.width * cur_reg.height;
        if (fin_fire)
        begin
            out_data_reg.keep      <= keep_box;
            out_data_reg.box_index <= idx_reg;
            out_data_reg.kept_slot <= mem_we ? slot_wide[5:0] : 6'd0;
            out_data_reg.overflow  <= keep_box && !room;
        end
    end

    // memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[AW-1:0]] <= cur_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[issue_reg[AW-1:0]];
        end
    end

    // overlap pipeline
    always_ff @(posedge clk)
    begin
        x0_reg  <= (cl > ql) ? cl : ql;
        y0_reg  <= (ct > qt) ? ct : qt;
        x1_reg  <= (cr < qr) ? cr : qr;
        y1_reg  <= (cb < qb) ? cb : qb;
        qw1_reg <= rdata_reg.width;
        qh1_reg <= rdata_reg.height;

        dx_reg  <= (x1_reg > x0_reg) ? dx_diff[15:0] : 16'd0;
        dy_reg  <= (y1_reg > y0_reg) ? dy_diff[15:0] : 16'd0;
        qw2_reg <= qw1_reg;
        qh2_reg <= qh1_reg;

        inter3_reg <= dx_reg * dy_reg;
        aq_reg     <= qw2_reg * qh2_reg;

        uni_reg    <= {1'b0, ap_reg} + {1'b0, aq_reg} - {1'b0, inter3_reg};
        inter4_reg <= inter3_reg;

        prod_reg <= prod_c;
        big_reg  <= {inter4_reg, 16'h0000};
        nz_reg   <= (uni_reg != 33'd0);
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("kept count above capacity");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (count_reg < MAX_CNT) && !hit_reg)
        else $error("kept-box write without room or after suppression");

    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (issue_reg < count_reg) && (state_reg == S_RUN))
        else $error("kept-box read beyond stored entries");

    a_hit_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> (state_reg == S_FIN) && (v_reg == 6'd0))
        else $error("scan did not stop after suppressing match");
`endif

endmodule
